// ===== rtl/core/qgp_pkg.sv =====
// Types, constants and term selection table for quaternion gyro propagation.
package qgp_pkg;

	typedef struct packed {
		logic signed [15:0] gyro_x;
		logic signed [15:0] gyro_y;
		logic signed [15:0] gyro_z;
	} gyro_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
	} quat_t;

	localparam logic [15:0] STEP_TIME_RESET = 16'd512;
	localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
	localparam logic [3:0] TERM_LAST = 4'd11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H_MUL,
		ST_H_ACC,
		ST_T_MUL,
		ST_T_ACC,
		ST_ABS,
		ST_SHIFT,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FIN
	} state_t;

	// One cross term h[hidx] * q[qidx], added to or subtracted from v[vidx].
	typedef struct packed {
		logic [1:0] hidx;
		logic [1:0] qidx;
		logic [1:0] vidx;
		logic       neg;
	} term_sel_t;

	function automatic term_sel_t term_sel(input logic [3:0] idx);
		term_sel_t t;
		case (idx)
			4'd0:    t = '{hidx: 2'd0, qidx: 2'd1, vidx: 2'd0, neg: 1'b1};
			4'd1:    t = '{hidx: 2'd1, qidx: 2'd2, vidx: 2'd0, neg: 1'b1};
			4'd2:    t = '{hidx: 2'd2, qidx: 2'd3, vidx: 2'd0, neg: 1'b1};
			4'd3:    t = '{hidx: 2'd0, qidx: 2'd0, vidx: 2'd1, neg: 1'b0};
			4'd4:    t = '{hidx: 2'd2, qidx: 2'd2, vidx: 2'd1, neg: 1'b0};
			4'd5:    t = '{hidx: 2'd1, qidx: 2'd3, vidx: 2'd1, neg: 1'b1};
			4'd6:    t = '{hidx: 2'd1, qidx: 2'd0, vidx: 2'd2, neg: 1'b0};
			4'd7:    t = '{hidx: 2'd2, qidx: 2'd1, vidx: 2'd2, neg: 1'b1};
			4'd8:    t = '{hidx: 2'd0, qidx: 2'd3, vidx: 2'd2, neg: 1'b0};
			4'd9:    t = '{hidx: 2'd2, qidx: 2'd0, vidx: 2'd3, neg: 1'b0};
			4'd10:   t = '{hidx: 2'd1, qidx: 2'd1, vidx: 2'd3, neg: 1'b0};
			4'd11:   t = '{hidx: 2'd0, qidx: 2'd2, vidx: 2'd3, neg: 1'b1};
			default: t = '{hidx: 2'd0, qidx: 2'd0, vidx: 2'd0, neg: 1'b0};
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/quaternion_gyro_propagate.sv =====
// Top level: gyro-driven quaternion attitude propagation with renormalization.
//
//  channel | handshake              | payload         | note
//  --------+------------------------+-----------------+------------------------------
//  gyro    | gyro_valid / gyro_stall| gyro (gyro_t)   | one rate sample per transfer
//  quat    | quat_valid / quat_stall| quat (quat_t)   | one normalized attitude
//  cfg     | cfg_we                 | cfg_wdata[15:0] | step time, Q0.16, no read-back
//
// Per sample: 3 rate products, 12 cross terms and 4 squares on the shared
// multiplier, up to 3 scaling shifts, the square root and, unless the root is
// zero, 4 divisions.
// Reset: attitude goes to identity, step time to 1/128 s, output empty.
// gyro_stall is high whenever a sample is in work. A waiting result in the
// output register does not block the next sample; only a finished update
// waits while the previous result is still stalled.
module quaternion_gyro_propagate (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           gyro_valid,
	output logic           gyro_stall,
	input  qgp_pkg::gyro_t gyro,
	output logic           quat_valid,
	input  logic           quat_stall,
	output qgp_pkg::quat_t quat,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata
);
	import qgp_pkg::*;

	state_t state_q, state_d;

	logic [3:0]         idx_q;
	logic [15:0]        step_time_q;
	logic signed [15:0] g_q   [3];
	logic signed [31:0] h_q   [3];
	logic signed [31:0] att_q [4];
	logic signed [39:0] v_q   [4];
	logic [39:0]        mag_q [4];
	logic [63:0]        sum_q;
	logic [31:0]        r_q;
	quat_t              quat_q;
	logic               quat_valid_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [63:0] rnd;
	logic signed [34:0] term;
	term_sel_t          sel;
	logic               over;
	logic               root_start, root_done;
	logic [31:0]        root_res;
	logic               div_start, div_done;
	logic [30:0]        div_quo;
	logic [61:0]        div_num;
	logic [30:0]        qclamp;
	logic               accept;
	logic               out_load;

	assign accept = gyro_valid && (state_q == ST_IDLE);
	assign sel    = term_sel(idx_q);

	// rounding to Q.30: add half, floor by 29
	assign rnd  = mul_p + 64'sd268435456;
	assign term = rnd[63:29];

	assign over = |mag_q[0][39:31] || |mag_q[1][39:31] ||
		|mag_q[2][39:31] || |mag_q[3][39:31];

	assign div_num = {mag_q[idx_q[1:0]][30:0], 30'b0} + {31'b0, r_q[31:1]};
	assign qclamp  = (div_quo > 31'd1073741824) ? 31'd1073741824 : div_quo;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_H_MUL: begin
				mul_a = 32'(g_q[idx_q[1:0]]);
				mul_b = {16'b0, step_time_q};
			end
			ST_T_MUL: begin
				mul_a = h_q[sel.hidx];
				mul_b = att_q[sel.qidx];
			end
			ST_SQ_MUL: begin
				mul_a = {1'b0, mag_q[idx_q[1:0]][30:0]};
				mul_b = {1'b0, mag_q[idx_q[1:0]][30:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	qgp_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	qgp_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (sum_q),
		.done   (root_done),
		.root   (root_res)
	);

	qgp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (r_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		root_start = 1'b0;
		div_start  = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE:     if (gyro_valid) state_d = ST_H_MUL;
			ST_H_MUL:    state_d = ST_H_ACC;
			ST_H_ACC:    state_d = (idx_q == 4'd2) ? ST_T_MUL : ST_H_MUL;
			ST_T_MUL:    state_d = ST_T_ACC;
			ST_T_ACC:    state_d = (idx_q == TERM_LAST) ? ST_ABS : ST_T_MUL;
			ST_ABS:      state_d = ST_SHIFT;
			ST_SHIFT:    if (!over) state_d = ST_SQ_MUL;
			ST_SQ_MUL:   state_d = ST_SQ_ACC;
			ST_SQ_ACC:   state_d = (idx_q == 4'd3) ? ST_ROOT_GO : ST_SQ_MUL;
			ST_ROOT_GO: begin
				root_start = 1'b1;
				state_d    = ST_ROOT_WAIT;
			end
			ST_ROOT_WAIT: begin
				if (root_done) state_d = (root_res == '0) ? ST_FIN : ST_DIV_GO;
			end
			ST_DIV_GO: begin
				div_start = 1'b1;
				state_d   = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_done) state_d = (idx_q == 4'd3) ? ST_FIN : ST_DIV_GO;
			end
			ST_FIN: begin
				if (!quat_valid_q || !quat_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: step time, attitude, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_time_q  <= STEP_TIME_RESET;
			att_q[0]     <= ONE_Q30;
			att_q[1]     <= '0;
			att_q[2]     <= '0;
			att_q[3]     <= '0;
			quat_valid_q <= 1'b0;
		end else begin
			if (cfg_we) step_time_q <= cfg_wdata;
			if (state_q == ST_ROOT_WAIT && root_done && root_res == '0) begin
				att_q[0] <= ONE_Q30;
				att_q[1] <= '0;
				att_q[2] <= '0;
				att_q[3] <= '0;
			end
			if (state_q == ST_DIV_WAIT && div_done) begin
				att_q[idx_q[1:0]] <= v_q[idx_q[1:0]][39] ?
					-$signed({1'b0, qclamp}) : $signed({1'b0, qclamp});
			end
			if (out_load) begin
				quat_valid_q <= 1'b1;
			end else if (!quat_stall) begin
				quat_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q <= '0;
				if (accept) begin
					g_q[0] <= gyro.gyro_x;
					g_q[1] <= gyro.gyro_y;
					g_q[2] <= gyro.gyro_z;
					for (int j = 0; j < 4; j++) v_q[j] <= 40'(att_q[j]);
				end
			end
			ST_H_ACC: begin
				h_q[idx_q[1:0]] <= mul_p[31:0];
				idx_q <= (idx_q == 4'd2) ? 4'd0 : idx_q + 4'd1;
			end
			ST_T_ACC: begin
				v_q[sel.vidx] <= sel.neg ? v_q[sel.vidx] - 40'(term)
					: v_q[sel.vidx] + 40'(term);
				idx_q <= (idx_q == TERM_LAST) ? 4'd0 : idx_q + 4'd1;
			end
			ST_ABS: begin
				for (int j = 0; j < 4; j++)
					mag_q[j] <= v_q[j][39] ? 40'(-v_q[j]) : 40'(v_q[j]);
				sum_q <= '0;
			end
			ST_SHIFT: begin
				if (over)
					for (int j = 0; j < 4; j++) mag_q[j] <= mag_q[j] >> 1;
			end
			ST_SQ_ACC: begin
				sum_q <= sum_q + 64'(mul_p);
				idx_q <= (idx_q == 4'd3) ? 4'd0 : idx_q + 4'd1;
			end
			ST_ROOT_WAIT: begin
				if (root_done) r_q <= root_res;
			end
			ST_DIV_WAIT: begin
				if (div_done) idx_q <= idx_q + 4'd1;
			end
			ST_FIN: begin
				if (out_load) begin
					quat_q.quat_w <= att_q[0];
					quat_q.quat_x <= att_q[1];
					quat_q.quat_y <= att_q[2];
					quat_q.quat_z <= att_q[3];
				end
			end
			default: begin
			end
		endcase
	end

	assign gyro_stall = (state_q != ST_IDLE);
	assign quat_valid = quat_valid_q;
	assign quat       = quat_q;
endmodule

// ===== rtl/core/qgp_mul.sv =====
// Shared signed 32x32 multiplier with registered product.
module qgp_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] p
);
	logic signed [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= 64'(a) * 64'(b);
	end

	assign p = p_q;
endmodule

// ===== rtl/core/qgp_root.sv =====
// Iterative integer square root, one result bit per cycle.
module qgp_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];
endmodule

// ===== rtl/core/qgp_div.sv =====
// Restoring divider, 62-bit numerator by 32-bit divisor, 31 quotient bits.
module qgp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [30:0] quo
);
	logic        run_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [30:0] lo_q;
	logic [30:0] quo_q;
	logic [32:0] t;
	logic        ge;

	// quotient fits 31 bits, so the top of the numerator is already below den
	assign t  = {rem_q[31:0], lo_q[30]};
	assign ge = t >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd30) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {2'b0, num[61:31]};
			lo_q  <= num[30:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? (t - {1'b0, den}) : t;
			lo_q  <= {lo_q[29:0], 1'b0};
			quo_q <= {quo_q[29:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
